// ===== hw/rtl/wbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int PIDX_W   = 6;
    localparam int PLEN_W   = 7;
    localparam int OFF_W    = 32;

    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_OFFSET_BITS = 32;

    localparam logic [BYTE_W-1:0] WILDCARD_RESET = 8'hAB;
    localparam logic [OFF_W-1:0]  OFF32_MAX      = 32'hFFFF_FFFF;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SCAN = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DATA = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic load_pat;
        logic begin_scan;
        logic shift;
        logic advance;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_active;
        logic has_result;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/wbps_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_in_if
// Input channel: valid/ready handshake with the scan item payload.
// ----------------------------------------------------------------------------
interface wbps_in_if;
    logic                               valid;
    logic                               ready;
    logic [wbps_pkg::ACTION_W-1:0]      action;
    logic [wbps_pkg::BYTE_W-1:0]        byte_value;
    logic [wbps_pkg::PIDX_W-1:0]        pattern_index;
    logic [wbps_pkg::PLEN_W-1:0]        pattern_length;
    logic [wbps_pkg::OFF_W-1:0]         scan_start;
    logic [wbps_pkg::OFF_W-1:0]         scan_end;
    logic                               last_byte;

    modport source (
        output valid, action, byte_value, pattern_index, pattern_length,
               scan_start, scan_end, last_byte,
        input  ready
    );
    modport sink (
        input  valid, action, byte_value, pattern_index, pattern_length,
               scan_start, scan_end, last_byte,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/wbps_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_out_if
// Output channel: valid/ready handshake with the match result payload.
// ----------------------------------------------------------------------------
interface wbps_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [wbps_pkg::OFF_W-1:0]    match_offset;

    modport source (
        output valid, found, match_offset,
        input  ready
    );
    modport sink (
        input  valid, found, match_offset,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/wildcard_byte_pattern_scanner.sv =====
`default_nettype none
// Load and begin-scan beats are accepted and applied in the idle state; a data
// beat is accepted, then its window is checked in the evaluate state, and its
// result is valid in the output register the cycle after the check. No new beat
// is accepted while a data beat is being checked; a result waiting on a full
// output register holds the check. Synchronous active-low reset clears control
// state, sets the wildcard to 0xAB; the pattern store is not reset.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams buffer bytes and reports the first window matching a wildcard pattern.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = wbps_pkg::DEF_OFFSET_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [wbps_pkg::BYTE_W-1:0] i_cfg_wr_data,
    wbps_in_if.sink                          i_in,
    wbps_out_if.source                       o_out
);

    wbps_pkg::t_cmd    cmd;
    wbps_pkg::t_status status;
    logic              in_ready;

    wbps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wbps_dp #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_byte_value     (i_in.byte_value),
        .i_pattern_index  (i_in.pattern_index),
        .i_pattern_length (i_in.pattern_length),
        .i_scan_start     (i_in.scan_start),
        .i_scan_end       (i_in.scan_end),
        .i_last_byte      (i_in.last_byte),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_found          (o_out.found),
        .o_match_offset   (o_out.match_offset)
    );

    assign i_in.ready = in_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/wbps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_ctrl
// Sequencer: accepts a beat, then evaluates the window for data beats.
// ----------------------------------------------------------------------------
module wbps_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [wbps_pkg::ACTION_W-1:0] i_in_action,
    output logic                               o_in_ready,
    input  wire wbps_pkg::t_status             i_status,
    output wbps_pkg::t_cmd                     o_cmd
);

    wbps_pkg::t_state r_state;
    wbps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            wbps_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_pat   = (i_in_action == wbps_pkg::ACT_LOAD);
                    o_cmd.begin_scan = (i_in_action == wbps_pkg::ACT_SCAN);
                    if (i_in_action == wbps_pkg::ACT_DATA && i_status.scan_active) begin
                        o_cmd.shift = 1'b1;
                        n_state     = wbps_pkg::S_EVAL;
                    end
                end
            end
            wbps_pkg::S_EVAL: begin
                if (!i_status.has_result) begin
                    o_cmd.advance = 1'b1;
                    n_state       = wbps_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.advance = 1'b1;
                    o_cmd.emit    = 1'b1;
                    n_state       = wbps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wbps_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wbps_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_dp
// Datapath: pattern and window cells, bound checks and result register.
// ----------------------------------------------------------------------------
module wbps_dp #(
    parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = wbps_pkg::DEF_OFFSET_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wbps_pkg::t_cmd                i_cmd,
    output wbps_pkg::t_status                  o_status,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [wbps_pkg::BYTE_W-1:0]   i_cfg_wr_data,
    input  wire logic [wbps_pkg::BYTE_W-1:0]   i_byte_value,
    input  wire logic [wbps_pkg::PIDX_W-1:0]   i_pattern_index,
    input  wire logic [wbps_pkg::PLEN_W-1:0]   i_pattern_length,
    input  wire logic [wbps_pkg::OFF_W-1:0]    i_scan_start,
    input  wire logic [wbps_pkg::OFF_W-1:0]    i_scan_end,
    input  wire logic                          i_last_byte,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_found,
    output logic [wbps_pkg::OFF_W-1:0]         o_match_offset
);

    localparam int CW  = ((OFFSET_BITS > wbps_pkg::OFF_W) ? OFFSET_BITS : wbps_pkg::OFF_W) + 1;
    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int PW  = $clog2(MAX_PATTERN);
    localparam int IW  = ((PW > wbps_pkg::PIDX_W) ? PW : wbps_pkg::PIDX_W) + 1;
    localparam int LCW = ((LW > wbps_pkg::PLEN_W) ? LW : wbps_pkg::PLEN_W) + 1;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic [wbps_pkg::BYTE_W-1:0] r_pat [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0] n_win [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0] r_wild;
    logic [MAX_PATTERN-1:0]      cell_ok;
    logic [OFFSET_BITS-1:0]      r_pos;
    logic [LW-1:0]               r_len;
    logic [LW-1:0]               n_len;
    logic [wbps_pkg::OFF_W-1:0]  r_start;
    logic [wbps_pkg::OFF_W-1:0]  r_end;
    logic                        r_active;
    logic                        r_last;
    logic                        r_out_valid;
    logic                        r_found;
    logic [wbps_pkg::OFF_W-1:0]  r_offset;

    logic [IW-1:0]  idx_ext;
    logic [LCW-1:0] len_ext;
    logic [CW-1:0]  pos_p1;
    logic [CW-1:0]  win_off;
    logic           win_ok;
    logic           hit;

    assign idx_ext = IW'(i_pattern_index);
    assign len_ext = LCW'(i_pattern_length);

    always_comb begin
        if (len_ext == '0) begin
            n_len = LW'(1);
        end else if (len_ext > LCW'(MAX_PATTERN)) begin
            n_len = LW'(MAX_PATTERN);
        end else begin
            n_len = len_ext[LW-1:0];
        end
    end

    // cell k holds the byte compared with pattern byte k; the newest byte
    // enters at cell len-1 and older bytes move toward cell 0
    always_comb begin
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            n_win[k] = (LW'(k + 1) == r_len) ? i_byte_value : r_win[k+1];
        end
        n_win[MAX_PATTERN-1] = i_byte_value;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            cell_ok[k] = (LW'(k) >= r_len) || (r_pat[k] == r_wild) || (r_pat[k] == r_win[k]);
        end
    end

    // window ending at the newest byte
    assign pos_p1  = CW'(r_pos) + CW'(1);
    assign win_off = pos_p1 - CW'(r_len);
    assign win_ok  = !r_last && (r_pos != POS_MAX) && (pos_p1 >= CW'(r_len))
                     && (win_off >= CW'(r_start))
                     && (win_off <= CW'(wbps_pkg::OFF32_MAX))
                     && ((r_end == '0) || (pos_p1 < CW'(r_end)));
    assign hit     = win_ok && (&cell_ok);

    assign o_status.scan_active = r_active;
    assign o_status.has_result  = hit || r_last;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pat && (idx_ext < IW'(MAX_PATTERN))) begin
            r_pat[idx_ext[PW-1:0]] <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_found  <= hit;
            r_offset <= hit ? win_off[wbps_pkg::OFF_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wild      <= wbps_pkg::WILDCARD_RESET;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= '0;
            end
            r_pos       <= '0;
            r_len       <= LW'(1);
            r_start     <= '0;
            r_end       <= '0;
            r_active    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wild <= i_cfg_wr_data;
            end
            if (i_cmd.begin_scan) begin
                r_len    <= n_len;
                r_start  <= i_scan_start;
                r_end    <= i_scan_end;
                r_pos    <= '0;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_win[k] <= '0;
                end
                r_active <= 1'b1;
            end
            if (i_cmd.shift) begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_win[k] <= n_win[k];
                end
                r_last  <= i_last_byte;
            end
            if (i_cmd.advance && (r_pos != POS_MAX)) begin
                r_pos <= r_pos + OFFSET_BITS'(1);
            end
            if (i_cmd.emit) begin
                r_active    <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

endmodule
`default_nettype wire

// ===== tb/tb_wildcard_byte_pattern_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scanner
// Drives pattern loads, scan commands and buffer bytes into the scanner, with
// random gaps and output stalls. A built-in scan predictor computes the
// expected match result for every data beat that ends a scan, and the output
// beats are compared field by field in order. Starts with a short directed
// table and then runs random scan sequences under several wildcard settings.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scanner;

    localparam int          MAXP          = wbps_pkg::DEF_MAX_PATTERN;
    localparam logic [32:0] POS_SAT       = 33'h0_FFFF_FFFF;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          DIR_ROWS      = 24;

    localparam logic [wbps_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [wbps_pkg::ACTION_W-1:0] action;
        logic [wbps_pkg::BYTE_W-1:0]   byte_value;
        logic [wbps_pkg::PIDX_W-1:0]   pattern_index;
        logic [wbps_pkg::PLEN_W-1:0]   pattern_length;
        logic [wbps_pkg::OFF_W-1:0]    scan_start;
        logic [wbps_pkg::OFF_W-1:0]    scan_end;
        logic                          last_byte;
    } t_beat;

    typedef struct packed {
        logic                       found;
        logic [wbps_pkg::OFF_W-1:0] match_offset;
    } t_verdict;

    typedef enum logic [1:0] {
        TYPED_NONE,
        TYPED_NO_RESULT,
        TYPED_RESULT
    } t_typed_kind;

    typedef struct packed {
        t_typed_kind kind;
        t_verdict    verdict;
    } t_typed;

    typedef struct packed {
        t_beat    beat;
        t_typed   typed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [wbps_pkg::BYTE_W-1:0] i_cfg_wr_data;

    wbps_in_if  in_if();
    wbps_out_if out_if();

    wildcard_byte_pattern_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // scan predictor state
    logic [wbps_pkg::BYTE_W-1:0] wild_q;
    logic [wbps_pkg::BYTE_W-1:0] pat_mem [MAXP];
    logic [wbps_pkg::BYTE_W-1:0] win_mem [MAXP];   // [0] is the newest byte
    logic [32:0]                 scan_pos;
    logic [wbps_pkg::PLEN_W-1:0] scan_len;
    logic [wbps_pkg::OFF_W-1:0]  scan_lo;
    logic [wbps_pkg::OFF_W-1:0]  scan_hi;
    bit                          scan_done;

    t_verdict verdict_q [$];
    t_typed   typed_q [$];

    // stimulus-side view of the pattern store
    logic [wbps_pkg::BYTE_W-1:0] pat_shadow [MAXP];
    bit                          pat_loaded [MAXP];
    logic [wbps_pkg::BYTE_W-1:0] wild_shadow;

    int unsigned cycle_cnt;
    int unsigned err_cnt;
    int unsigned beats_sent;
    int unsigned verdicts_made;
    int unsigned hits_seen;
    int unsigned misses_seen;
    int unsigned wild_writes;
    int unsigned in_idle_pct;
    int unsigned out_stall_pct;

    t_row dir_table [DIR_ROWS];

    function automatic void scan_reset();
        wild_q    = wbps_pkg::WILDCARD_RESET;
        scan_pos  = '0;
        scan_len  = 7'd1;
        scan_lo   = '0;
        scan_hi   = '0;
        scan_done = 1'b1;
        for (int k = 0; k < MAXP; k++) win_mem[k] = '0;
    endfunction

    function automatic bit window_hit();
        logic [wbps_pkg::BYTE_W-1:0] pat;
        for (int k = 0; k < scan_len; k++) begin
            pat = pat_mem[k];
            if (pat != wild_q && pat != win_mem[scan_len - 1 - k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit scan_beat(input t_beat b, output t_verdict v);
        logic [32:0] p;
        logic [32:0] off;
        bit          chk;
        v = '0;
        case (b.action)
            wbps_pkg::ACT_LOAD: begin
                pat_mem[b.pattern_index] = b.byte_value;
                return 1'b0;
            end
            wbps_pkg::ACT_SCAN: begin
                scan_len = (b.pattern_length == 0) ? 7'd1 :
                           (b.pattern_length > MAXP) ? 7'(MAXP) : b.pattern_length;
                scan_lo   = b.scan_start;
                scan_hi   = b.scan_end;
                scan_pos  = '0;
                scan_done = 1'b0;
                for (int k = 0; k < MAXP; k++) win_mem[k] = '0;
                return 1'b0;
            end
            wbps_pkg::ACT_DATA: begin
                if (scan_done) return 1'b0;
                for (int k = MAXP - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
                win_mem[0] = b.byte_value;
                p   = scan_pos;
                chk = !b.last_byte && p < POS_SAT && (p + 33'd1) >= 33'(scan_len);
                if (chk) begin
                    off = p + 33'd1 - 33'(scan_len);
                    if (off < {1'b0, scan_lo} || off > POS_SAT) chk = 1'b0;
                    if (scan_hi != 0 && !(p + 33'd1 < {1'b0, scan_hi})) chk = 1'b0;
                    if (chk && window_hit()) begin
                        scan_done = 1'b1;
                        v.found = 1'b1;
                        v.match_offset = off[wbps_pkg::OFF_W-1:0];
                        return 1'b1;
                    end
                end
                if (p < POS_SAT) scan_pos = p + 33'd1;
                if (b.last_byte) begin
                    scan_done = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // result check and prediction
    always @(posedge i_clk) begin
        t_beat    b;
        t_verdict mv;
        t_verdict want;
        t_typed   te;
        bit       has;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_wildcard_byte_pattern_scanner NOT OK");
            $finish;
        end else if (!i_rst_n) begin
            scan_reset();
        end else begin
            if (i_cfg_wr_en) wild_q = i_cfg_wr_data;
            if (out_if.valid && out_if.ready) begin
                if (out_if.found) hits_seen++;
                else misses_seen++;
                if (verdict_q.size() == 0) begin
                    $error("result beat with none expected: found=%0d match_offset=%0h",
                           out_if.found, out_if.match_offset);
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_if.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, out_if.found);
                        err_cnt++;
                    end
                    if (out_if.match_offset !== want.match_offset) begin
                        $error("match_offset: expected %0h, got %0h",
                               want.match_offset, out_if.match_offset);
                        err_cnt++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                b.action         = in_if.action;
                b.byte_value     = in_if.byte_value;
                b.pattern_index  = in_if.pattern_index;
                b.pattern_length = in_if.pattern_length;
                b.scan_start     = in_if.scan_start;
                b.scan_end       = in_if.scan_end;
                b.last_byte      = in_if.last_byte;
                if (typed_q.size() != 0) te = typed_q.pop_front();
                else te = '{TYPED_NONE, '0};
                has = scan_beat(b, mv);
                case (te.kind)
                    TYPED_RESULT: begin
                        verdict_q.push_back(te.verdict);
                        verdicts_made++;
                    end
                    TYPED_NO_RESULT: ;
                    default: begin
                        if (has) begin
                            verdict_q.push_back(mv);
                            verdicts_made++;
                        end
                    end
                endcase
            end
        end
    end

    // output backpressure
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    function automatic t_row dir_row(input logic [wbps_pkg::ACTION_W-1:0] act,
                                     input logic [wbps_pkg::BYTE_W-1:0] val,
                                     input logic [wbps_pkg::PIDX_W-1:0] idx,
                                     input logic [wbps_pkg::PLEN_W-1:0] len,
                                     input logic [wbps_pkg::OFF_W-1:0] st,
                                     input logic [wbps_pkg::OFF_W-1:0] en,
                                     input logic last,
                                     input t_typed_kind kind,
                                     input logic fnd,
                                     input logic [wbps_pkg::OFF_W-1:0] off);
        t_row r;
        r.beat  = '{act, val, idx, len, st, en, last};
        r.typed = '{kind, '{fnd, off}};
        return r;
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        b.action         = wbps_pkg::ACTION_W'($urandom_range(3));
        b.byte_value     = wbps_pkg::BYTE_W'($urandom_range(255));
        b.pattern_index  = wbps_pkg::PIDX_W'($urandom_range(63));
        b.pattern_length = wbps_pkg::PLEN_W'($urandom_range(127));
        b.scan_start     = $urandom;
        b.scan_end       = $urandom;
        b.last_byte      = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic int unsigned written_prefix();
        for (int k = 0; k < MAXP; k++) if (!pat_loaded[k]) return k;
        return MAXP;
    endfunction

    task automatic push_beat(input t_beat b, input t_typed_kind kind = TYPED_NONE,
                             input t_verdict v = '0);
        t_typed tv;
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        tv.kind    = kind;
        tv.verdict = v;
        typed_q.push_back(tv);
        in_if.valid          <= 1'b1;
        in_if.action         <= b.action;
        in_if.byte_value     <= b.byte_value;
        in_if.pattern_index  <= b.pattern_index;
        in_if.pattern_length <= b.pattern_length;
        in_if.scan_start     <= b.scan_start;
        in_if.scan_end       <= b.scan_end;
        in_if.last_byte      <= b.last_byte;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        if (b.action == wbps_pkg::ACT_LOAD) begin
            pat_shadow[b.pattern_index] = b.byte_value;
            pat_loaded[b.pattern_index] = 1'b1;
        end
        beats_sent++;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_wildcard(input logic [wbps_pkg::BYTE_W-1:0] val);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        wild_shadow = val;
        wild_writes++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // one scan: optional pattern reload, begin-scan, then the buffer bytes
    task automatic gen_scan_run();
        int unsigned                 r;
        int unsigned                 eff;
        int unsigned                 n_bytes;
        int unsigned                 cut;
        int unsigned                 at;
        logic [wbps_pkg::PLEN_W-1:0] len_field;
        logic [wbps_pkg::OFF_W-1:0]  st;
        logic [wbps_pkg::OFF_W-1:0]  en;
        logic [wbps_pkg::BYTE_W-1:0] stream [$];
        t_beat                       b;
        bit                          broken;
        r = $urandom_range(99);
        if (r < 70) len_field = wbps_pkg::PLEN_W'($urandom_range(6, 1));
        else if (r < 88) len_field = wbps_pkg::PLEN_W'($urandom_range(20, 7));
        else if (r < 95) len_field = wbps_pkg::PLEN_W'($urandom_range(63, 21));
        else len_field = wbps_pkg::PLEN_W'($urandom_range(127, 64));
        eff = (len_field > MAXP) ? MAXP : len_field;

        if (written_prefix() < eff || $urandom_range(99) < 60) begin
            for (int k = 0; k < eff; k++) begin
                b = rand_beat();
                b.action = wbps_pkg::ACT_LOAD;
                b.pattern_index = wbps_pkg::PIDX_W'(k);
                r = $urandom_range(99);
                if (r < 25) b.byte_value = wild_shadow;
                else if (r < 60) b.byte_value = {$urandom_range(1) ? 4'hA : 4'h5,
                                                 $urandom_range(1) ? 4'h5 : 4'hF};
                push_beat(b);
            end
        end

        r = $urandom_range(99);
        st = (r < 70) ? '0 : (r < 90) ? wbps_pkg::OFF_W'($urandom_range(8)) : $urandom;
        if (eff <= 20) n_bytes = $urandom_range(eff + 16, 1);
        else n_bytes = $urandom_range(eff + 10, eff);
        r = $urandom_range(99);
        if (r < 60) en = '0;
        else if (r < 85) en = $urandom_range(n_bytes + 2);
        else if (r < 95) en = $urandom;
        else en = wbps_pkg::OFF32_MAX;

        for (int i = 0; i < n_bytes; i++)
            stream.push_back($urandom_range(1) ? pat_shadow[$urandom_range(eff - 1)]
                                               : wbps_pkg::BYTE_W'($urandom_range(255)));
        if (n_bytes >= eff && $urandom_range(99) < 65) begin
            at = $urandom_range(n_bytes - eff);
            for (int k = 0; k < eff; k++)
                if (pat_shadow[k] != wild_shadow) stream[at + k] = pat_shadow[k];
        end

        broken = ($urandom_range(99) < 8);
        cut = broken ? $urandom_range(n_bytes) : n_bytes;

        b = rand_beat();
        b.action = wbps_pkg::ACT_SCAN;
        b.pattern_length = len_field;
        b.scan_start = st;
        b.scan_end = en;
        push_beat(b);
        for (int i = 0; i < cut; i++) begin
            b = rand_beat();
            b.action = wbps_pkg::ACT_DATA;
            b.byte_value = stream[i];
            b.last_byte = !broken && (i == n_bytes - 1);
            push_beat(b);
        end
    endtask

    task automatic run_phase(input int unsigned beats_goal);
        int unsigned stop_at;
        int unsigned r;
        t_beat       b;
        stop_at = beats_sent + beats_goal;
        while (beats_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 10) begin
                b = rand_beat();
                if (r < 4) b.action = ACT_UNUSED;
                else if (r < 8) b.action = wbps_pkg::ACT_DATA;
                else b.action = wbps_pkg::ACT_LOAD;
                push_beat(b);
            end else begin
                gen_scan_run();
            end
        end
    endtask

    initial begin
        cycle_cnt = 0;
        err_cnt = 0;
        beats_sent = 0;
        verdicts_made = 0;
        hits_seen = 0;
        misses_seen = 0;
        wild_writes = 0;
        in_idle_pct = 37;
        out_stall_pct = 37;
        wild_shadow = wbps_pkg::WILDCARD_RESET;
        for (int k = 0; k < MAXP; k++) begin
            pat_mem[k] = '0;
            pat_shadow[k] = '0;
            pat_loaded[k] = 1'b0;
        end
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        in_if.valid          = 1'b0;
        in_if.action         = wbps_pkg::ACT_LOAD;
        in_if.byte_value     = '0;
        in_if.pattern_index  = '0;
        in_if.pattern_length = '0;
        in_if.scan_start     = '0;
        in_if.scan_end       = '0;
        in_if.last_byte      = 1'b0;

        dir_table = '{
            // data with no scan running, unused action, pattern loads
            dir_row(wbps_pkg::ACT_DATA, 8'h55, 6'd0,  7'd0,   '0,        '0,        1'b1,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(ACT_UNUSED,         8'h00, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_LOAD, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_LOAD, 8'hFF, 6'd1,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_LOAD, 8'hAB, 6'd2,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_LOAD, 8'h5A, 6'd63, 7'd0,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            // 00 FF <wild> at offset 0
            dir_row(wbps_pkg::ACT_SCAN, 8'h00, 6'd0,  7'd3,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'hFF, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h77, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_RESULT, 1'b1, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h11, 6'd0,  7'd0,   '0,        '0,        1'b1,
                    TYPED_NO_RESULT, 1'b0, '0),
            // zero length, window on the last byte never counts
            dir_row(wbps_pkg::ACT_SCAN, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b1,
                    TYPED_RESULT, 1'b0, '0),
            // end bound below pattern length
            dir_row(wbps_pkg::ACT_SCAN, 8'h00, 6'd0,  7'd2,   '0,        32'd1,     1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'hFF, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b1,
                    TYPED_RESULT, 1'b0, '0),
            // oversize length and top bounds, each scan dropped by the next
            dir_row(wbps_pkg::ACT_SCAN, 8'hFF, 6'd63, 7'd127,
                    wbps_pkg::OFF32_MAX, wbps_pkg::OFF32_MAX, 1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_SCAN, 8'h00, 6'd0,  7'd1,
                    wbps_pkg::OFF32_MAX, wbps_pkg::OFF32_MAX, 1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0),
            dir_row(wbps_pkg::ACT_SCAN, 8'h00, 6'd0,  7'd2,   '0,        '0,        1'b0,
                    TYPED_NO_RESULT, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h12, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'h00, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0),
            dir_row(wbps_pkg::ACT_DATA, 8'hFF, 6'd0,  7'd0,   '0,        '0,        1'b0,
                    TYPED_NONE, 1'b0, '0)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            push_beat(dir_table[i].beat, dir_table[i].typed.kind, dir_table[i].typed.verdict);

        write_wildcard(8'h00);
        run_phase(135);

        // full-rate stretch: no gaps, no stalls
        write_wildcard(8'hFF);
        in_idle_pct = 0;
        out_stall_pct = 0;
        run_phase(135);
        in_idle_pct = 37;
        out_stall_pct = 37;

        write_wildcard(wbps_pkg::BYTE_W'($urandom_range(255)));
        run_phase(135);

        write_wildcard(wbps_pkg::WILDCARD_RESET);
        run_phase(135);

        settle();

        $display("covered %0d input beats and %0d result beats (%0d matches, %0d misses)",
                 beats_sent, hits_seen + misses_seen, hits_seen, misses_seen);
        $display("wildcard written %0d times, %0d field mismatches", wild_writes, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_wildcard_byte_pattern_scanner OK");
        end else begin
            $display("tb_wildcard_byte_pattern_scanner NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_in_if.sv
hw/rtl/wbps_out_if.sv
hw/rtl/wbps_ctrl.sv
hw/rtl/wbps_dp.sv
hw/rtl/wildcard_byte_pattern_scanner.sv
tb/tb_wildcard_byte_pattern_scanner.sv
